// File: hdl/srar_pkg.sv
// Package for the sequence range add, reverse and maximum block.
// Holds the request and response word types, operation codes and the controller states.
// Depends on nothing.
package srar_pkg;

   localparam int unsigned POS_WIDTH = 11;
   localparam int unsigned VALUE_WIDTH = 64;
   localparam logic [POS_WIDTH-1:0] RESET_LENGTH = 11'd1024;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_REVERSE = 2'd1;
   localparam logic [1:0] OP_MAX = 2'd2;

   typedef struct packed {
      logic [1:0]                    operation;
      logic [POS_WIDTH-1:0]          first_position;
      logic [POS_WIDTH-1:0]          last_position;
      logic signed [VALUE_WIDTH-1:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] range_maximum;
      logic                          status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_DRAIN,
      S_SWAP_A,
      S_SWAP_B,
      S_SWAP_C,
      S_SWAP_D,
      S_DONE
   } state_type;

endpackage

// File: hdl/sequence_range_add_reverse_max.sv
// Range add, reverse and maximum over a sequence held in one element memory; uses srar_pkg.
// Add and max walk the range element by element; reverse swaps pairs of elements from both
// ends inward; a one-position reverse or a rejected word goes straight to the response. A
// response not yet taken holds the next word in its final state.
// Throughput: one word at a time; one element a cycle for add and max.
// Reset: synchronous; a clearing pass zeroes every element before the first word is taken.
module sequence_range_add_reverse_max #(
   parameter int MAX_LENGTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  srar_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output srar_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [srar_pkg::POS_WIDTH-1:0]       csr_data
);

   localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LENGTH - 1);

   logic [srar_pkg::VALUE_WIDTH-1:0] mem [MAX_LENGTH];

   srar_pkg::state_type state_ff, state_in;
   logic [srar_pkg::POS_WIDTH-1:0] len_ff, len_in;
   srar_pkg::req_type req_ff, req_in;
   logic err_ff, err_in;
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in, clr_ff, clr_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic pend_ff, pend_in;
   logic have_ff, have_in;
   logic signed [srar_pkg::VALUE_WIDTH-1:0] best_ff, best_in;
   logic [srar_pkg::VALUE_WIDTH-1:0] hold_ff, hold_in;
   logic [srar_pkg::VALUE_WIDTH-1:0] mem_q_ff;
   logic rsp_valid_ff, rsp_valid_in;
   srar_pkg::rsp_type rsp_ff, rsp_in;

   logic req_accept;
   logic req_bad;
   logic [AW-1:0] first_addr, last_addr;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;
   logic [srar_pkg::VALUE_WIDTH-1:0] wr_data;
   logic more_pairs;
   logic rsp_free;

   assign req_ready = (state_ff == srar_pkg::S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign req_bad = (req_data.operation != srar_pkg::OP_ADD
                     && req_data.operation != srar_pkg::OP_REVERSE
                     && req_data.operation != srar_pkg::OP_MAX)
                    || (req_data.first_position == '0)
                    || (req_data.first_position > req_data.last_position)
                    || (req_data.last_position > len_ff)
                    || (32'(req_data.last_position) > 32'(MAX_LENGTH));
   assign first_addr = AW'(req_data.first_position - 11'd1);
   assign last_addr = AW'(req_data.last_position - 11'd1);
   assign more_pairs = ({1'b0, lo_ff} + (AW+1)'(2)) < {1'b0, hi_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srar_pkg::S_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = srar_pkg::S_IDLE;
            end
         end
         srar_pkg::S_IDLE: begin
            if (req_accept) begin
               priority if (req_bad) begin
                  state_in = srar_pkg::S_DONE;
               end else if (req_data.operation == srar_pkg::OP_REVERSE) begin
                  state_in = (first_addr < last_addr) ? srar_pkg::S_SWAP_A : srar_pkg::S_DONE;
               end else begin
                  state_in = srar_pkg::S_WALK;
               end
            end
         end
         srar_pkg::S_WALK: begin
            if (ptr_ff == hi_ff) begin
               state_in = srar_pkg::S_DRAIN;
            end
         end
         srar_pkg::S_DRAIN: state_in = srar_pkg::S_DONE;
         srar_pkg::S_SWAP_A: state_in = srar_pkg::S_SWAP_B;
         srar_pkg::S_SWAP_B: state_in = srar_pkg::S_SWAP_C;
         srar_pkg::S_SWAP_C: state_in = srar_pkg::S_SWAP_D;
         srar_pkg::S_SWAP_D: state_in = more_pairs ? srar_pkg::S_SWAP_C : srar_pkg::S_DONE;
         srar_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = srar_pkg::S_IDLE;
            end
         end
         default: state_in = srar_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      len_in = csr_valid ? csr_data : len_ff;
      req_in = req_ff;
      err_in = err_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      ptr_in = ptr_ff;
      clr_in = clr_ff;
      pend_in = 1'b0;
      pend_addr_in = pend_addr_ff;
      have_in = have_ff;
      best_in = best_ff;
      hold_in = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      rd_addr = ptr_ff;
      wr_en = 1'b0;
      wr_addr = pend_addr_ff;
      wr_data = mem_q_ff + req_ff.amount;

      if ((state_ff == srar_pkg::S_WALK || state_ff == srar_pkg::S_DRAIN) && pend_ff) begin
         if (req_ff.operation == srar_pkg::OP_ADD) begin
            wr_en = 1'b1;
         end else if (!have_ff || ($signed(mem_q_ff) > best_ff)) begin
            best_in = $signed(mem_q_ff);
            have_in = 1'b1;
         end
      end

      unique case (state_ff)
         srar_pkg::S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in = clr_ff + AW'(1);
         end
         srar_pkg::S_IDLE: begin
            if (req_accept) begin
               req_in = req_data;
               err_in = req_bad;
               lo_in = first_addr;
               hi_in = last_addr;
               ptr_in = first_addr;
               have_in = 1'b0;
               best_in = '0;
            end
         end
         srar_pkg::S_WALK: begin
            rd_addr = ptr_ff;
            ptr_in = ptr_ff + AW'(1);
            pend_in = 1'b1;
            pend_addr_in = ptr_ff;
         end
         srar_pkg::S_DRAIN: begin
         end
         srar_pkg::S_SWAP_A: begin
            rd_addr = lo_ff;
         end
         srar_pkg::S_SWAP_B: begin
            rd_addr = hi_ff;
            hold_in = mem_q_ff;
         end
         srar_pkg::S_SWAP_C: begin
            wr_en = 1'b1;
            wr_addr = lo_ff;
            wr_data = mem_q_ff;
            rd_addr = lo_ff + AW'(1);
         end
         srar_pkg::S_SWAP_D: begin
            wr_en = 1'b1;
            wr_addr = hi_ff;
            wr_data = hold_ff;
            hold_in = mem_q_ff;
            rd_addr = hi_ff - AW'(1);
            lo_in = lo_ff + AW'(1);
            hi_in = hi_ff - AW'(1);
         end
         srar_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = err_ff;
               rsp_in.range_maximum = (!err_ff && req_ff.operation == srar_pkg::OP_MAX)
                                      ? best_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srar_pkg::S_CLEAR;
         len_ff <= srar_pkg::RESET_LENGTH;
         clr_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         clr_ff <= clr_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      err_ff <= err_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ptr_ff <= ptr_in;
      pend_addr_ff <= pend_addr_in;
      have_ff <= have_in;
      best_ff <= best_in;
      hold_ff <= hold_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != srar_pkg::S_IDLE && state_ff != srar_pkg::S_DONE))
      else $error("Memory written while no operation is running.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == srar_pkg::S_WALK) |-> (ptr_ff <= hi_ff))
      else $error("Walk pointer passed the end of the range.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == srar_pkg::S_SWAP_C || state_ff == srar_pkg::S_SWAP_D)
      |-> (lo_ff < hi_ff && wr_addr != rd_addr))
      else $error("Swap pointers crossed or read and write hit the same entry.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status) |-> (rsp_ff.range_maximum == '0))
      else $error("Rejected word carries a nonzero maximum.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == srar_pkg::S_DONE && rsp_free) |=> rsp_valid_ff)
      else $error("Finished operation did not raise the response.");
`endif

endmodule

// File: dv/sequence_range_add_reverse_max_tb.sv
// Self-checking testbench for sequence_range_add_reverse_max: drives request words, length
// writes and response back-pressure, and checks every response against a shadow sequence.
// Depends on srar_pkg and the sequence_range_add_reverse_max RTL.
module sequence_range_add_reverse_max_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [srar_pkg::POS_WIDTH-1:0] pos_type;
   typedef logic signed [srar_pkg::VALUE_WIDTH-1:0] value_type;

   localparam int MAX_LEN = 1024;
   localparam int unsigned TIMEOUT_CYCLES = 6000000;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam value_type VALUE_MIN = {1'b1, {(srar_pkg::VALUE_WIDTH-1){1'b0}}};
   localparam value_type VALUE_MAX = {1'b0, {(srar_pkg::VALUE_WIDTH-1){1'b1}}};

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   class range_op_scoreboard;
      value_type         shadow_values [MAX_LEN];
      pos_type           length;
      srar_pkg::rsp_type expected_rsp_q [$];
      int                failures;

      function new();
         foreach (shadow_values[i]) shadow_values[i] = '0;
         length = srar_pkg::RESET_LENGTH;
         failures = 0;
      endfunction

      function void set_length(pos_type value);
         length = value;
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      function void note_request(srar_pkg::req_type w);
         srar_pkg::rsp_type expected;
         int unsigned       eff;
         int unsigned       lo;
         int unsigned       hi;
         value_type         best;
         value_type         held;
         eff = (length > MAX_LEN) ? MAX_LEN : 32'(length);
         expected.range_maximum = '0;
         expected.status = 1'b0;
         if (w.operation > srar_pkg::OP_MAX || w.first_position == 0
               || w.first_position > w.last_position || w.last_position > eff) begin
            expected.status = 1'b1;
         end else begin
            lo = 32'(w.first_position) - 32'd1;
            hi = 32'(w.last_position) - 32'd1;
            case (w.operation)
               srar_pkg::OP_ADD: begin
                  for (int unsigned i = lo; i <= hi; i++)
                     shadow_values[i] = shadow_values[i] + w.amount;
               end
               srar_pkg::OP_REVERSE: begin
                  while (lo < hi) begin
                     held = shadow_values[lo];
                     shadow_values[lo] = shadow_values[hi];
                     shadow_values[hi] = held;
                     lo++;
                     hi--;
                  end
               end
               default: begin
                  best = shadow_values[lo];
                  for (int unsigned i = lo + 1; i <= hi; i++)
                     if (shadow_values[i] > best) best = shadow_values[i];
                  expected.range_maximum = best;
               end
            endcase
         end
         expected_rsp_q.push_back(expected);
      endfunction

      function void check_response(srar_pkg::rsp_type got);
         srar_pkg::rsp_type expected;
         if (expected_rsp_q.size() == 0) begin
            $error("response word with no request outstanding");
            failures++;
         end else begin
            expected = expected_rsp_q.pop_front();
            if (got.range_maximum !== expected.range_maximum) begin
               $error("range_maximum: expected %0d, got %0d",
                      expected.range_maximum, got.range_maximum);
               failures++;
            end
            if (got.status !== expected.status) begin
               $error("status: expected %0d, got %0d", expected.status, got.status);
               failures++;
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   srar_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   srar_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   pos_type           csr_data;

   range_op_scoreboard sb;
   int                 tx_idle_pct;
   int                 rx_stall_pct;
   int                 hold_cycles;
   int unsigned        cycle_count;

   sequence_range_add_reverse_max #(
      .MAX_LENGTH(MAX_LEN)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input srar_pkg::req_type w);
      int gaps;
      gaps = 0;
      while (gaps < 20 && tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) gaps++;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
      @(negedge clock);
   endtask

   task automatic send_op(input logic [1:0] op, input int first, input int last,
                          input value_type amount);
      srar_pkg::req_type w;
      w.operation = op;
      w.first_position = pos_type'(first);
      w.last_position = pos_type'(last);
      w.amount = amount;
      send_word(w);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(input pos_type length_value, input int count,
                            input idle_mode_type mode, input bit pressure);
      srar_pkg::req_type w;
      int                eff;
      int                roll;
      int                span;
      int                first;
      int                last;
      int                offset;
      req_valid <= 1'b0;
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= length_value;
      do @(posedge clock); while (!csr_ready);
      sb.set_length(length_value);
      @(negedge clock);
      csr_valid <= 1'b0;
      tx_idle_pct = (mode == IDLE_SENDER) ? 49 : (mode == IDLE_BOTH) ? 18 : 0;
      rx_stall_pct = (mode == IDLE_RECEIVER) ? 49 : (mode == IDLE_BOTH) ? 18 : 0;
      if (pressure) hold_cycles = HOLD_OFF_CYCLES;
      eff = (length_value > MAX_LEN) ? MAX_LEN : int'(length_value);
      repeat (count) begin
         roll = $urandom_range(0, 99);
         w.operation = 2'($urandom_range(0, 2));
         w.amount = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0: w.amount = VALUE_MIN;
            1: w.amount = VALUE_MAX;
            2: w.amount = value_type'(-1);
            3: begin
               offset = $urandom_range(0, 20);
               w.amount = value_type'(offset - 10);
            end
            default: ;
         endcase
         if (roll < 8 || eff == 0) begin
            w.operation = 2'($urandom_range(0, 3));
            first = $urandom_range(0, 2047);
            last = $urandom_range(0, 2047);
         end else if (roll < 14) begin
            case ($urandom_range(0, 2))
               0: begin
                  first = 0;
                  last = $urandom_range(1, eff);
               end
               1: begin
                  last = $urandom_range(1, eff);
                  first = last + $urandom_range(1, 4);
               end
               default: begin
                  first = $urandom_range(1, eff);
                  last = eff + $urandom_range(1, 2047 - eff);
               end
            endcase
         end else begin
            if ($urandom_range(0, 99) < 85) span = $urandom_range(1, (eff < 16) ? eff : 16);
            else span = $urandom_range(1, eff);
            first = $urandom_range(1, eff - span + 1);
            last = first + span - 1;
         end
         w.first_position = pos_type'(first);
         w.last_position = pos_type'(last);
         send_word(w);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_cycles = 0;
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_op(srar_pkg::OP_MAX, 1, 1024, 0);
      send_op(srar_pkg::OP_ADD, 1, 1024, VALUE_MAX);
      send_op(srar_pkg::OP_ADD, 1, 1, VALUE_MIN);
      send_op(srar_pkg::OP_ADD, 1024, 1024, 1);
      send_op(srar_pkg::OP_MAX, 1, 1024, 0);
      send_op(srar_pkg::OP_MAX, 1024, 1024, 0);
      send_op(srar_pkg::OP_REVERSE, 1, 1024, 0);
      send_op(srar_pkg::OP_MAX, 1, 1, 0);
      send_op(srar_pkg::OP_MAX, 1024, 1024, 0);
      send_op(srar_pkg::OP_REVERSE, 3, 3, 0);
      send_op(srar_pkg::OP_REVERSE, 1, 2, 0);
      send_op(srar_pkg::OP_ADD, 2, 5, -5);
      send_op(srar_pkg::OP_MAX, 1, 6, 0);
      send_op(OP_UNUSED, 1, 4, 7);
      send_op(srar_pkg::OP_MAX, 0, 4, 0);
      send_op(srar_pkg::OP_REVERSE, 9, 8, 0);
      send_op(srar_pkg::OP_ADD, 1, 1025, 3);
      send_op(srar_pkg::OP_MAX, 2047, 2047, 0);
      send_op(srar_pkg::OP_ADD, 1024, 1024, 0);
      send_op(srar_pkg::OP_MAX, 1023, 1024, 0);

      run_phase(11'd16, 90, IDLE_NONE, 1'b0);
      run_phase(11'd2047, 70, IDLE_SENDER, 1'b0);
      run_phase(11'd0, 15, IDLE_RECEIVER, 1'b0);
      run_phase(11'd7, 80, IDLE_BOTH, 1'b0);
      run_phase(11'd1024, 70, IDLE_NONE, 1'b1);
      run_phase(11'd1, 25, IDLE_SENDER, 1'b0);
      run_phase(11'd200, 80, IDLE_RECEIVER, 1'b0);
      run_phase(11'd1025, 70, IDLE_BOTH, 1'b0);
      run_phase(11'd33, 80, IDLE_SENDER, 1'b0);

      req_valid <= 1'b0;
      wait_drained();
      repeat (2 * MAX_LEN + 8) @(posedge clock);
      if (sb.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
